// ===== rtl/cos_pkg.sv =====
`default_nettype none

package cos_pkg;

  // Field widths
  localparam int unsigned EPOCH_W  = 63;
  localparam int unsigned MONO_W   = 32;
  localparam int unsigned OFFS_W   = 64;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned TS_W     = 12;

  // Width of the timestamp counter inside the logical time
  localparam int unsigned TIMESTAMP_BITS = 12;

  // Timestamp mask: low TIMESTAMP_BITS ones, clipped to the port width
  localparam logic [TS_W-1:0] TS_MASK = (TIMESTAMP_BITS >= TS_W) ? {TS_W{1'b1}} :
      TS_W'((64'd1 << TIMESTAMP_BITS) - 64'd1);

  // Register reset values
  localparam logic [CFG_W-1:0] SLEW_THRESHOLD_RST = 16'd50;
  localparam logic [CFG_W-1:0] MAX_SLEW_STEP_RST  = 16'd1;

  // Largest positive 63-bit time
  localparam logic [OFFS_W-1:0] MAX63 = {1'b0, {(OFFS_W-1){1'b1}}};

  // Request codes
  typedef enum logic [1:0] {
    FUNC_SYNC = 2'd0,
    FUNC_SLEW = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEW_STEP  = 4'd1;

endpackage

`default_nettype wire

// ===== rtl/clock_offset_step_slew_top.sv =====
`default_nettype none

// Channel  Handshake                    Payload
// -------  ---------------------------  ------------------------------------------------
// in       in_valid / in_stall          func, sync_epoch_ms, status_ok, monotonic_ms
// out      out_valid / out_stall        ok, synced, logical_time_ms, timestamp_low,
//                                       last_error_ms
// cfg      cfg_wr_en, cfg_index         cfg_data (16 bit)
//
// An accepted request loads the input register; one pass of 64-bit
// add/compare/select logic then carries it into the result register once that
// register is empty or being drained.
// One request per cycle is sustained while out_stall is low; the offset state
// is updated in the same edge that loads the result, so the next request sees it at once.
// rst is synchronous, active high; it clears the offsets, error, synced flag,
// and sets the threshold to 50 ms and the slew step to 1 ms.
// A stalled result holds; the input register still takes a request while the
// result register is empty or being drained.

module clock_offset_step_slew_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      func,
  input  wire logic [cos_pkg::EPOCH_W-1:0]     sync_epoch_ms,
  input  wire logic                            status_ok,
  input  wire logic [cos_pkg::MONO_W-1:0]      monotonic_ms,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 ok,
  output logic                                 synced,
  output logic [cos_pkg::EPOCH_W-1:0]          logical_time_ms,
  output logic [cos_pkg::TS_W-1:0]             timestamp_low,
  output logic signed [cos_pkg::OFFS_W-1:0]    last_error_ms,
  input  wire logic                            cfg_wr_en,
  input  wire logic [cos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cos_pkg::CFG_W-1:0]       cfg_data
);
  import cos_pkg::*;

  // Input register
  logic                s1_valid;
  func_t               s1_func;
  logic [EPOCH_W-1:0]  s1_epoch;
  logic                s1_status;
  logic [MONO_W-1:0]   s1_mono;
  logic                s1_advance;

  // Clock state and configuration
  logic [OFFS_W-1:0]   cur_offset;
  logic [OFFS_W-1:0]   tgt_offset;
  logic [OFFS_W-1:0]   last_error;
  logic                synced_flag;
  logic [CFG_W-1:0]    slew_threshold;
  logic [CFG_W-1:0]    max_slew_step;

  logic [OFFS_W-1:0]   cur_offset_next;
  logic [OFFS_W-1:0]   tgt_offset_next;
  logic [OFFS_W-1:0]   last_error_next;
  logic                synced_flag_next;
  logic                ok_next;
  logic [OFFS_W-1:0]   ltime_next;

  // Datapath terms
  logic [OFFS_W-1:0]   desired;
  logic [OFFS_W-1:0]   diff;
  logic                diff_ovf;
  logic [OFFS_W-1:0]   err;
  logic [OFFS_W-1:0]   err_mag;
  logic                err_big;
  logic [OFFS_W-1:0]   step;
  logic                tgt_above;
  logic [OFFS_W-1:0]   gap;
  logic                gap_big;
  logic [OFFS_W-1:0]   sum_time;

  // Move the request into the result register when it is empty or draining
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_comb begin
    // Sync error: desired offset minus current, saturated
    desired  = {1'b0, s1_epoch} - {{(OFFS_W-MONO_W){1'b0}}, s1_mono};
    diff     = desired - cur_offset;
    diff_ovf = (desired[OFFS_W-1] ^ cur_offset[OFFS_W-1]) &
               (desired[OFFS_W-1] ^ diff[OFFS_W-1]);
    if (diff_ovf) begin
      err = desired[OFFS_W-1] ? {1'b1, {(OFFS_W-1){1'b0}}} : MAX63;
    end else begin
      err = diff;
    end
    err_mag = err[OFFS_W-1] ? (OFFS_W'(0) - err) : err;
    err_big = err_mag > {{(OFFS_W-CFG_W){1'b0}}, slew_threshold};

    // Slew: exact gap toward the target against the step size
    step      = {{(OFFS_W-CFG_W){1'b0}}, max_slew_step};
    tgt_above = $signed(tgt_offset) > $signed(cur_offset);
    gap       = tgt_above ? (tgt_offset - cur_offset) : (cur_offset - tgt_offset);
    gap_big   = gap > step;

    // Read: logical time with saturation
    sum_time = cur_offset + {{(OFFS_W-MONO_W){1'b0}}, s1_mono};
  end

  always_comb begin
    cur_offset_next  = cur_offset;
    tgt_offset_next  = tgt_offset;
    last_error_next  = last_error;
    synced_flag_next = synced_flag;
    ok_next          = 1'b0;
    ltime_next       = '0;
    case (s1_func)
      FUNC_SYNC: begin
        if (!s1_status) begin
          synced_flag_next = 1'b0;
        end else begin
          ok_next = 1'b1;
          tgt_offset_next = desired;
          if (!synced_flag) begin
            cur_offset_next  = desired;
            last_error_next  = '0;
            synced_flag_next = 1'b1;
          end else begin
            last_error_next = err;
            if (err_big) begin
              cur_offset_next = desired;
            end
          end
        end
      end
      FUNC_SLEW: begin
        if (synced_flag) begin
          ok_next = 1'b1;
          if (!gap_big) begin
            cur_offset_next = tgt_offset;
          end else if (tgt_above) begin
            cur_offset_next = cur_offset + step;
          end else begin
            cur_offset_next = cur_offset - step;
          end
        end
      end
      FUNC_READ: begin
        if (synced_flag && !(cur_offset[OFFS_W-1] && sum_time[OFFS_W-1])) begin
          ok_next    = 1'b1;
          ltime_next = sum_time[OFFS_W-1] ? MAX63 : sum_time;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_func   <= func_t'(func);
      s1_epoch  <= sync_epoch_ms;
      s1_status <= status_ok;
      s1_mono   <= monotonic_ms;
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      slew_threshold <= SLEW_THRESHOLD_RST;
      max_slew_step  <= MAX_SLEW_STEP_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_SLEW_THRESHOLD) begin
        slew_threshold <= cfg_data;
      end
      if (cfg_index == CFG_MAX_SLEW_STEP) begin
        max_slew_step <= cfg_data;
      end
    end
  end

  // Commit clock state with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_offset  <= '0;
      tgt_offset  <= '0;
      last_error  <= '0;
      synced_flag <= 1'b0;
    end else if (s1_advance) begin
      cur_offset  <= cur_offset_next;
      tgt_offset  <= tgt_offset_next;
      last_error  <= last_error_next;
      synced_flag <= synced_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
    if (s1_advance) begin
      ok              <= ok_next;
      synced          <= synced_flag_next;
      logical_time_ms <= ltime_next[EPOCH_W-1:0];
      timestamp_low   <= ltime_next[TS_W-1:0] & TS_MASK;
      last_error_ms   <= last_error_next;
    end
  end

endmodule

`default_nettype wire
